/* rtl/core/rgbcc_pkg.sv */
// Shared types and constants for the RGB chromaticity color classifier.
// Holds the fixed tristimulus coefficients, the color class codes and the
// threshold flag bundle passed between the compare and decision stages.
`default_nettype none

package rgbcc_pkg;

  // Width of each raw count port
  localparam int RgbW = 16;

  // Signed coefficient width (largest magnitude is 389834)
  localparam int CoefW = 20;

  // Rows: X, Y, S = X + Y + Z. Columns: red, green, blue.
  // Values are the float coefficients scaled by 100000.
  localparam int RowN = 3;
  localparam int ChanN = 3;
  localparam int RowX = 0;
  localparam int RowY = 1;
  localparam int RowS = 2;

  localparam logic signed [CoefW-1:0] CoefTab [RowN][ChanN] = '{
    '{-20'sd14282,  20'sd154924, -20'sd95641},
    '{-20'sd32466,  20'sd157837, -20'sd73191},
    '{-20'sd114950, 20'sd389834, -20'sd112500}
  };

  // Color class codes
  typedef enum logic [2:0] {
    ClsRed    = 3'd0,
    ClsBlue   = 3'd1,
    ClsGreen  = 3'd2,
    ClsYellow = 3'd3,
    ClsWhite  = 3'd4,
    ClsViolet = 3'd5,
    ClsOrange = 3'd6,
    ClsInval  = 3'd7
  } rgbcc_class_e;

  // Threshold results, x and y in tenths, after sign normalization
  typedef struct packed {
    logic s_zero;
    logic tx_ge0;
    logic tx_ge2;
    logic tx_ge3;
    logic tx_ge4;
    logic tx_ge5;
    logic tx_ge6;
    logic tx_ge9;
    logic ty_ge1;
    logic ty_ge2;
    logic ty_ge3;
    logic ty_ge4;
    logic ty_le4;
    logic ty_ge6;
    logic ty_le9;
  } rgbcc_flags_t;

endpackage

`default_nettype wire

/* rtl/core/rgbcc_tristim.sv */
// Tristimulus stages: nine constant multiplies, then the X, Y and S sums.
// Depends on rgbcc_pkg for the coefficient table.
`default_nettype none

module rgbcc_tristim
  import rgbcc_pkg::*;
#(
  parameter int CountBits = 16,
  localparam int ProdW = CountBits + CoefW + 1,
  localparam int SumW = ProdW + 2
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire logic [RgbW-1:0]        red_count_i,
  input  wire logic [RgbW-1:0]        green_count_i,
  input  wire logic [RgbW-1:0]        blue_count_i,
  output logic                        valid_o,
  output logic signed [SumW-1:0]      sum_x_o,
  output logic signed [SumW-1:0]      sum_y_o,
  output logic signed [SumW-1:0]      sum_s_o
);

  logic [CountBits-1:0]        cnt [ChanN];
  logic signed [ProdW-1:0]     prod_d [RowN][ChanN];
  logic signed [ProdW-1:0]     prod_q [RowN][ChanN];
  logic signed [SumW-1:0]      sum_d [RowN];
  logic signed [SumW-1:0]      sum_q [RowN];
  logic                        v1_q;
  logic                        v2_q;

  // Keep only the low count bits
  assign cnt[0] = red_count_i[CountBits-1:0];
  assign cnt[1] = green_count_i[CountBits-1:0];
  assign cnt[2] = blue_count_i[CountBits-1:0];

  // Form every coefficient product
  always_comb begin
    for (int r = 0; r < RowN; r++) begin
      for (int c = 0; c < ChanN; c++) begin
        prod_d[r][c] = $signed(ProdW'({1'b0, cnt[c]})) * ProdW'(CoefTab[r][c]);
      end
    end
  end

  // Add the three products of each row
  always_comb begin
    for (int r = 0; r < RowN; r++) begin
      sum_d[r] = SumW'(prod_q[r][0]) + SumW'(prod_q[r][1]) + SumW'(prod_q[r][2]);
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign sum_x_o = sum_q[RowX];
  assign sum_y_o = sum_q[RowY];
  assign sum_s_o = sum_q[RowS];

endmodule

`default_nettype wire

/* rtl/core/rgbcc_ratio.sv */
// Ratio stages: sign normalization by the sum, then the tenth-step
// threshold compares of 10*X and 10*Y against k*S. Depends on rgbcc_pkg for the flags.
`default_nettype none

module rgbcc_ratio
  import rgbcc_pkg::*;
#(
  parameter int CountBits = 16,
  localparam int SumW = CountBits + CoefW + 3,
  localparam int CmpW = SumW + 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire logic signed [SumW-1:0] sum_x_i,
  input  wire logic signed [SumW-1:0] sum_y_i,
  input  wire logic signed [SumW-1:0] sum_s_i,
  output logic                        valid_o,
  output rgbcc_flags_t                flags_o
);

  logic                    neg;
  logic signed [SumW-1:0]  xa_q;
  logic signed [SumW-1:0]  ya_q;
  logic signed [SumW-1:0]  sa_q;
  logic                    zero_q;
  logic signed [CmpW-1:0]  tx;
  logic signed [CmpW-1:0]  ty;
  logic signed [CmpW-1:0]  s1;
  logic signed [CmpW-1:0]  s2;
  logic signed [CmpW-1:0]  s3;
  logic signed [CmpW-1:0]  s4;
  logic signed [CmpW-1:0]  s5;
  logic signed [CmpW-1:0]  s6;
  logic signed [CmpW-1:0]  s9;
  rgbcc_flags_t            flags_d;
  rgbcc_flags_t            flags_q;
  logic                    v3_q;
  logic                    v4_q;

  // Flip all three signs when the sum is negative
  assign neg = sum_s_i[SumW-1];

  always_ff @(posedge clk_i) begin
    xa_q   <= neg ? -sum_x_i : sum_x_i;
    ya_q   <= neg ? -sum_y_i : sum_y_i;
    sa_q   <= neg ? -sum_s_i : sum_s_i;
    zero_q <= (sum_s_i == '0);
  end

  // Scale by ten and form the sum multiples with shifts and adds
  assign tx = (CmpW'(xa_q) <<< 3) + (CmpW'(xa_q) <<< 1);
  assign ty = (CmpW'(ya_q) <<< 3) + (CmpW'(ya_q) <<< 1);
  assign s1 = CmpW'(sa_q);
  assign s2 = s1 <<< 1;
  assign s4 = s1 <<< 2;
  assign s3 = s2 + s1;
  assign s5 = s4 + s1;
  assign s6 = s4 + s2;
  assign s9 = (s1 <<< 3) + s1;

  // Compare against each threshold
  always_comb begin
    flags_d.s_zero = zero_q;
    flags_d.tx_ge0 = !tx[CmpW-1];
    flags_d.tx_ge2 = (tx >= s2);
    flags_d.tx_ge3 = (tx >= s3);
    flags_d.tx_ge4 = (tx >= s4);
    flags_d.tx_ge5 = (tx >= s5);
    flags_d.tx_ge6 = (tx >= s6);
    flags_d.tx_ge9 = (tx >= s9);
    flags_d.ty_ge1 = (ty >= s1);
    flags_d.ty_ge2 = (ty >= s2);
    flags_d.ty_ge3 = (ty >= s3);
    flags_d.ty_ge4 = (ty >= s4);
    flags_d.ty_le4 = (ty <= s4);
    flags_d.ty_ge6 = (ty >= s6);
    flags_d.ty_le9 = (ty <= s9);
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  assign valid_o = v4_q;
  assign flags_o = flags_q;

  // Thresholds are ordered once the sum is nonzero
  property p_tx_order;
    @(posedge clk_i) disable iff (!rst_ni)
      (v4_q && !flags_q.s_zero && flags_q.tx_ge9) |-> (flags_q.tx_ge4 && flags_q.tx_ge0);
  endproperty
  a_tx_order: assert property (p_tx_order)
    else $error("rgbcc_ratio: x threshold flags out of order");

endmodule

`default_nettype wire

/* rtl/core/rgbcc_decide.sv */
// Decision stage: walks the threshold cascade and registers the color class.
// Depends on rgbcc_pkg for the flag bundle and the class codes.
`default_nettype none

module rgbcc_decide
  import rgbcc_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire rgbcc_flags_t  flags_i,
  output logic               valid_o,
  output rgbcc_class_e       class_o
);

  rgbcc_class_e class_d;
  rgbcc_class_e class_q;
  logic         v5_q;

  // Walk the cascade in order
  always_comb begin
    priority if (flags_i.s_zero) begin
      class_d = ClsInval;
    end else if (flags_i.tx_ge0 && !flags_i.tx_ge4) begin
      priority if (flags_i.tx_ge3 && flags_i.ty_ge3 && flags_i.ty_le4) begin
        class_d = ClsWhite;
      end else if (!flags_i.ty_le4 && flags_i.ty_le9) begin
        class_d = ClsGreen;
      end else if (!flags_i.tx_ge3 && flags_i.ty_le4 && flags_i.ty_ge1) begin
        class_d = ClsBlue;
      end else if (!flags_i.tx_ge2 && !flags_i.ty_ge1) begin
        class_d = ClsBlue;
      end else if (flags_i.tx_ge3 && !flags_i.ty_ge3 && flags_i.ty_ge2) begin
        class_d = ClsRed;
      end else begin
        class_d = ClsViolet;
      end
    end else if (flags_i.tx_ge4 && !flags_i.tx_ge9) begin
      priority if (!flags_i.tx_ge5 && flags_i.ty_ge3 && !flags_i.ty_ge6) begin
        class_d = ClsYellow;
      end else if (flags_i.tx_ge5 && !flags_i.tx_ge6 && flags_i.ty_ge4 &&
                   !flags_i.ty_ge6) begin
        class_d = ClsOrange;
      end else if (!flags_i.tx_ge5 && flags_i.ty_ge6) begin
        class_d = ClsGreen;
      end else begin
        class_d = ClsRed;
      end
    end else begin
      class_d = ClsInval;
    end
  end

  always_ff @(posedge clk_i) begin
    class_q <= class_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= valid_i;
    end
  end

  assign valid_o = v5_q;
  assign class_o = class_q;

  // A zero sum always ends as invalid
  property p_zero_inval;
    @(posedge clk_i) disable iff (!rst_ni)
      (valid_i && flags_i.s_zero) |=> (class_q == ClsInval);
  endproperty
  a_zero_inval: assert property (p_zero_inval)
    else $error("rgbcc_decide: zero sum not classified invalid");

  // x at or beyond nine tenths is invalid
  property p_high_x_inval;
    @(posedge clk_i) disable iff (!rst_ni)
      (valid_i && flags_i.tx_ge9) |=> (class_q == ClsInval);
  endproperty
  a_high_x_inval: assert property (p_high_x_inval)
    else $error("rgbcc_decide: x above range not classified invalid");

endmodule

`default_nettype wire

/* rtl/core/rgb_chromaticity_color_classifier_unit.sv */
// Top level of the RGB chromaticity color classifier.
// Instantiates rgbcc_tristim, rgbcc_ratio and rgbcc_decide; uses rgbcc_pkg.
//
// Each transaction carries raw red, green and blue counts; a pulse on start
// takes one in every cycle (busy stays low, the pipeline never stalls).
// At the end of the pipeline done_o pulses for one cycle with color_class_o:
// 0 red, 1 blue, 2 green, 3 yellow, 4 white/black, 5 violet, 6 orange,
// 7 invalid. The five register stages are the coefficient multiplies, the
// X/Y/S sums, sign normalization by the sum, the tenth-step compares and the
// class cascade. The receiver cannot hold a result off, so it must take
// done_o whenever it rises. Only the low COUNT_BITS bits of each count are
// used. Nothing is stored between transactions.
`default_nettype none

module rgb_chromaticity_color_classifier_unit
  import rgbcc_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [RgbW-1:0]  red_count_i,
  input  wire logic [RgbW-1:0]  green_count_i,
  input  wire logic [RgbW-1:0]  blue_count_i,
  output logic                  done_o,
  output logic [2:0]            color_class_o
);

  localparam int SumW = COUNT_BITS + CoefW + 3;

  logic                    accept;
  logic                    sum_valid;
  logic signed [SumW-1:0]  sum_x;
  logic signed [SumW-1:0]  sum_y;
  logic signed [SumW-1:0]  sum_s;
  logic                    flags_valid;
  rgbcc_flags_t            flags;
  rgbcc_class_e            color_class;

  // Pipeline takes a transaction in every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  rgbcc_tristim #(
    .CountBits (COUNT_BITS)
  ) u_tristim (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (accept),
    .red_count_i   (red_count_i),
    .green_count_i (green_count_i),
    .blue_count_i  (blue_count_i),
    .valid_o       (sum_valid),
    .sum_x_o       (sum_x),
    .sum_y_o       (sum_y),
    .sum_s_o       (sum_s)
  );

  rgbcc_ratio #(
    .CountBits (COUNT_BITS)
  ) u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .sum_x_i (sum_x),
    .sum_y_i (sum_y),
    .sum_s_i (sum_s),
    .valid_o (flags_valid),
    .flags_o (flags)
  );

  rgbcc_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (flags_valid),
    .flags_i (flags),
    .valid_o (done_o),
    .class_o (color_class)
  );

  assign color_class_o = color_class;

  // Every accepted transaction yields a result
  property p_accept_done;
    @(posedge clk_i) disable iff (!rst_ni)
      accept |-> ##5 done_o;
  endproperty
  a_accept_done: assert property (p_accept_done)
    else $error("rgbcc: accepted transaction produced no result");

  // No result appears without a matching transaction
  property p_done_accept;
    @(posedge clk_i) disable iff (!rst_ni)
      done_o |-> $past(accept, 5);
  endproperty
  a_done_accept: assert property (p_done_accept)
    else $error("rgbcc: result without accepted transaction");

endmodule

`default_nettype wire
